// File: design/dst1_normal_mode_transform_top_assert.svh
// Assertion macros for the DST-I normal-mode transform block.
`ifndef DST1_NORMAL_MODE_TRANSFORM_TOP_ASSERT_SVH
`define DST1_NORMAL_MODE_TRANSFORM_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define DST1_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dst1 assertion failed");

// Check that cons holds in the cycle after ante.
`define DST1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dst1 assertion failed");

`else

`define DST1_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DST1_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/dst1_pkg.sv
// Package: sizes, constants and the coefficient magnitude table of the DST-I block.
`default_nettype none

package dst1_pkg;

    localparam int POINTS         = 32;
    localparam int COEF_FRAC_BITS = 16;
    localparam int SAMPLE_W       = 24;
    localparam int IDX_OUT_W      = 5;

    localparam int IDX_W     = $clog2(POINTS);
    localparam int MOD       = POINTS + 1;
    localparam int MOD2      = 2 * MOD;
    localparam int K_W       = $clog2(MOD2);
    localparam int MAG_N     = MOD / 2 + 1;
    localparam int MAG_IDX_W = $clog2(MAG_N);
    localparam int MAG_W     = COEF_FRAC_BITS + 1;
    localparam int COEF_W    = MAG_W + 1;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + $clog2(POINTS);

    localparam logic [IDX_W-1:0]     LAST_IDX      = IDX_W'(POINTS - 1);
    localparam logic [IDX_OUT_W-1:0] LAST_MODE_IDX = IDX_OUT_W'(POINTS - 1);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] MOD64   = 64'(MOD);

    localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] Q_MAX      = (ACC_W + 1)'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W:0] Q_MIN      = ~Q_MAX;

    localparam logic [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    typedef logic [MAG_W-1:0] mag_table_t [MAG_N];

    // Bit-by-bit integer square root, one result bit per step.
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_q;
        v     = v_in;
        res   = '0;
        bit_q = 64'd1 << 62;
        for (int n = 0; n < 32; n++)
        begin
            if (v >= res + bit_q)
            begin
                v   = v - (res + bit_q);
                res = (res >> 1) + bit_q;
            end
            else
            begin
                res = res >> 1;
            end
            bit_q = bit_q >> 2;
        end
        return res;
    endfunction

    localparam logic [63:0] SCALE_Q30 = isqrt64((64'd1 << 61) / MOD64);

    // sin(pi*k/MOD) in Q30 by Taylor series through the x^21 term.
    function automatic logic [63:0] sin_q30(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (PI_Q30 * k) / MOD64;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + signed'(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        if (sum > signed'(ONE_Q30))
        begin
            sum = signed'(ONE_Q30);
        end
        return unsigned'(sum);
    endfunction

    // Coefficient magnitude for each folded angle index 0..MOD/2.
    function automatic mag_table_t build_mag_table();
        mag_table_t  tbl;
        logic [63:0] mag;
        for (int kk = 0; kk < MAG_N; kk++)
        begin
            mag = sin_q30(64'(kk)) * SCALE_Q30;
            mag = (mag + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
            tbl[kk] = MAG_W'(mag);
        end
        return tbl;
    endfunction

    localparam mag_table_t MAG_TABLE = build_mag_table();

endpackage

`default_nettype wire

// File: design/dst1_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dst1_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_q[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/dst1_normal_mode_transform_top.sv
// Top level of the orthonormal DST-I normal-mode transform.
`default_nettype none

`include "dst1_normal_mode_transform_top_assert.svh"

// DST-I transform over POINTS (32) signed Q8.16 samples. Samples enter one per
// cycle while sample_ready is high, in index order, and are written to a sample
// RAM; the request carrying the last sample of a block starts the transform, and
// the block emits POINTS results, mode 0 first, each rounded half up to Q8.16 and
// saturated with a flag. All results come from one shared multiply-accumulate fed
// by a single RAM read port, through the coefficient, product and accumulate
// stages. sample_ready is low while the RAM is being read for a block; results
// still draining from the pipeline do not block the next block's samples. A
// stalled mode output holds the whole multiply-accumulate pipeline.
module dst1_normal_mode_transform_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_ready,
    input  wire logic signed [dst1_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                    mode_valid,
    input  wire logic                               mode_ready,
    output logic signed [dst1_pkg::SAMPLE_W-1:0]    mode_value,
    output logic [dst1_pkg::IDX_OUT_W-1:0]          mode_index,
    output logic                                    last_mode,
    output logic                                    saturated
);

    import dst1_pkg::*;

    // Load and issue control
    logic             sample_fire;
    logic             busy_reg;
    logic [IDX_W-1:0] load_cnt_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [K_W-1:0]   k_reg;
    logic             adv;
    logic             stall;
    logic             issue;
    logic             row_end;

    // Coefficient lookup
    logic [K_W-1:0]           k_unf;
    logic [K_W-1:0]           k_fold;
    logic                     k_neg;
    logic [MAG_W-1:0]         mag;
    logic signed [COEF_W-1:0] coef_mag;
    logic signed [COEF_W-1:0] coef;
    logic [K_W:0]             k_add;
    logic [K_W:0]             k_wrap;

    // Pipeline
    logic                     v_s1_reg;
    logic                     first_s1_reg;
    logic                     end_s1_reg;
    logic [IDX_W-1:0]         idx_s1_reg;
    logic signed [COEF_W-1:0] coef_s1_reg;
    logic [SAMPLE_W-1:0]      ram_rdata;

    logic                     v_s2_reg;
    logic                     first_s2_reg;
    logic                     end_s2_reg;
    logic [IDX_W-1:0]         idx_s2_reg;
    logic signed [PROD_W-1:0] prod_s2_reg;

    logic                     done_s3_reg;
    logic [IDX_W-1:0]         idx_s3_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Rounding and output
    logic signed [ACC_W:0]    t_round;
    logic signed [ACC_W:0]    q_round;
    logic                     sat_hi;
    logic                     sat_lo;
    logic                     out_valid_reg;
    logic [SAMPLE_W-1:0]      mode_value_reg;
    logic [IDX_OUT_W-1:0]     mode_index_reg;
    logic                     last_mode_reg;
    logic                     sat_reg;

    assign sample_ready = !busy_reg;
    assign sample_fire  = sample_valid && sample_ready;

    // Hold the whole pipeline while a finished row cannot reach the output.
    assign stall   = done_s3_reg && out_valid_reg && !mode_ready;
    assign adv     = !stall;
    assign issue   = adv && busy_reg;
    assign row_end = (j_reg == LAST_IDX);

    dst1_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(POINTS)
    ) u_sample_ram (
        .clk  (clk),
        .we   (sample_fire),
        .waddr(load_cnt_reg),
        .wdata(sample_in),
        .re   (issue),
        .raddr(j_reg),
        .rdata(ram_rdata)
    );

    // Fold k = (i+1)(j+1) mod 2M onto the first quarter wave.
    always_comb
    begin
        k_neg    = (k_reg >= K_W'(MOD));
        k_unf    = k_neg ? (k_reg - K_W'(MOD)) : k_reg;
        k_fold   = ((K_W'(MOD) - k_unf) < k_unf) ? (K_W'(MOD) - k_unf) : k_unf;
        mag      = MAG_TABLE[k_fold[MAG_IDX_W-1:0]];
        coef_mag = signed'({1'b0, mag});
        coef     = k_neg ? -coef_mag : coef_mag;
        k_add    = {1'b0, k_reg} + (K_W + 1)'(i_reg) + (K_W + 1)'(1);
        k_wrap   = (k_add >= (K_W + 1)'(MOD2)) ? (k_add - (K_W + 1)'(MOD2)) : k_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            if (sample_fire)
            begin
                if (load_cnt_reg == LAST_IDX)
                begin
                    load_cnt_reg <= '0;
                    busy_reg     <= 1'b1;
                    i_reg        <= '0;
                    j_reg        <= '0;
                    k_reg        <= K_W'(1);
                end
                else
                begin
                    load_cnt_reg <= load_cnt_reg + IDX_W'(1);
                end
            end
            else if (issue)
            begin
                if (row_end)
                begin
                    j_reg <= '0;
                    k_reg <= K_W'(i_reg) + K_W'(2);
                    i_reg <= i_reg + IDX_W'(1);
                    if (i_reg == LAST_IDX)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                    k_reg <= k_wrap[K_W-1:0];
                end
            end
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg    <= 1'b0;
            v_s2_reg    <= 1'b0;
            done_s3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_s1_reg    <= busy_reg;
            v_s2_reg    <= v_s1_reg;
            done_s3_reg <= v_s2_reg && end_s2_reg;
        end
    end

    // Stage payloads: coefficient, product, accumulate.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            first_s1_reg <= (j_reg == '0);
            end_s1_reg   <= row_end;
            idx_s1_reg   <= i_reg;
            coef_s1_reg  <= coef;

            first_s2_reg <= first_s1_reg;
            end_s2_reg   <= end_s1_reg;
            idx_s2_reg   <= idx_s1_reg;
            prod_s2_reg  <= PROD_W'(signed'(ram_rdata)) * PROD_W'(coef_s1_reg);

            idx_s3_reg   <= idx_s2_reg;
            if (v_s2_reg)
            begin
                if (first_s2_reg)
                begin
                    acc_reg <= ACC_W'(prod_s2_reg);
                end
                else
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_s2_reg);
                end
            end
        end
    end

    // Round half up, then clamp to Q8.16.
    always_comb
    begin
        t_round = (ACC_W + 1)'(acc_reg) + ROUND_HALF;
        q_round = t_round >>> COEF_FRAC_BITS;
        sat_hi  = (q_round > Q_MAX);
        sat_lo  = (q_round < Q_MIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_s3_reg && adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (mode_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_s3_reg && adv)
        begin
            if (sat_hi)
            begin
                mode_value_reg <= OUT_MAX;
            end
            else if (sat_lo)
            begin
                mode_value_reg <= OUT_MIN;
            end
            else
            begin
                mode_value_reg <= q_round[SAMPLE_W-1:0];
            end
            mode_index_reg <= IDX_OUT_W'(idx_s3_reg);
            last_mode_reg  <= (idx_s3_reg == LAST_IDX);
            sat_reg        <= sat_hi || sat_lo;
        end
    end

    assign mode_valid = out_valid_reg;
    assign mode_value = signed'(mode_value_reg);
    assign mode_index = mode_index_reg;
    assign last_mode  = last_mode_reg;
    assign saturated  = sat_reg;

    `DST1_ASSERT_NEXT(a_stall_holds_acc, clk, rst_n, stall, $stable(acc_reg))
    `DST1_ASSERT_SAME(a_last_mode_index, clk, rst_n, mode_valid && last_mode, mode_index == LAST_MODE_IDX)
    `DST1_ASSERT_SAME(a_sat_clamped, clk, rst_n, mode_valid && saturated, mode_value_reg == OUT_MAX || mode_value_reg == OUT_MIN)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the DST-I normal-mode transform: sample blocks in, checked mode results out.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dst1_pkg::POINTS, dst1_pkg::COEF_FRAC_BITS, dst1_pkg::SAMPLE_W, dst1_pkg::IDX_OUT_W;

    localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
    localparam longint unsigned UNIT_Q30      = 64'd1 << 30;
    localparam longint          SAT_HI        = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint          SAT_LO        = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    localparam int HOLD_AT     = POINTS / 4;
    localparam int HOLD_LEN    = 1500;
    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 200;

    typedef enum int {PH_FREE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_e;
    typedef enum int {FILL_FULL, FILL_ALIGNED, FILL_MIXED} fill_kind_e;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        bit                         wait_drain;
    } sample_req_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_OUT_W-1:0]       index;
        logic                       last;
        logic                       sat;
    } mode_result_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] sample_in    = '0;
    logic                       mode_valid;
    logic                       mode_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] mode_value;
    logic [IDX_OUT_W-1:0]       mode_index;
    logic                       last_mode;
    logic                       saturated;

    longint                     coef_tab [POINTS][POINTS];
    logic signed [SAMPLE_W-1:0] sample_buf [POINTS];
    int                         fill_cnt = 0;

    sample_req_t  stim_q [$];
    mode_result_t mode_q [$];
    mode_result_t mode_head;

    int   samples_taken = 0;
    int   results_got   = 0;
    int   total_items   = 0;
    int   err_cnt       = 0;
    int   idle_cycles   = 0;
    int   hold_left     = 0;
    bit   hold_done     = 1'b0;
    logic drain_armed   = 1'b0;

    dst1_normal_mode_transform_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_in    (sample_in),
        .mode_valid   (mode_valid),
        .mode_ready   (mode_ready),
        .mode_value   (mode_value),
        .mode_index   (mode_index),
        .last_mode    (last_mode),
        .saturated    (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Floor square root by bisection; v stays below 2^62.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 31;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // sin(pi*k/m) in Q30, Taylor series through x^21, each term truncated.
    function automatic longint sine_q30(input longint unsigned k, input longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (HALF_TURN_Q30 * k) / m;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(UNIT_Q30))
            acc = longint'(UNIT_Q30);
        return acc;
    endfunction

    task automatic build_coefs();
        longint unsigned m;
        longint unsigned scale;
        longint unsigned k;
        longint unsigned kk;
        longint unsigned mag;
        bit              neg;
        m     = POINTS + 1;
        scale = floor_root((64'd1 << 61) / m);
        for (int i = 0; i < POINTS; i++)
        begin
            for (int j = 0; j < POINTS; j++)
            begin
                k   = longint'((i + 1) * (j + 1)) % (2 * m);
                neg = (k >= m);
                kk  = neg ? k - m : k;
                // fold the angle into the first quadrant
                if (m - kk < kk)
                    kk = m - kk;
                mag = longint'(sine_q30(kk, m)) * scale;
                mag = (mag + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
                coef_tab[i][j] = neg ? -longint'(mag) : longint'(mag);
            end
        end
    endtask

    // Store one sample; on the last sample of a block queue all mode results.
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        longint       acc;
        longint       q;
        mode_result_t r;
        sample_buf[fill_cnt] = s;
        if (fill_cnt != POINTS - 1)
        begin
            fill_cnt++;
            return;
        end
        fill_cnt = 0;
        for (int i = 0; i < POINTS; i++)
        begin
            acc = 0;
            for (int j = 0; j < POINTS; j++)
                acc += longint'(sample_buf[j]) * coef_tab[i][j];
            // round half up, then drop the coefficient fraction
            q     = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            r.sat = 1'b0;
            if (q > SAT_HI)
            begin
                q     = SAT_HI;
                r.sat = 1'b1;
            end
            if (q < SAT_LO)
            begin
                q     = SAT_LO;
                r.sat = 1'b1;
            end
            r.value = q[SAMPLE_W-1:0];
            r.index = IDX_OUT_W'(i);
            r.last  = (i == POINTS - 1);
            mode_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (err_cnt < 100)
            $display("%0t mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic add_block(input fill_kind_e kind, input int count, input bit neg,
                             input bit wait_first);
        int                         row;
        logic signed [SAMPLE_W-1:0] v;
        row = $urandom_range(0, POINTS - 1);
        for (int j = 0; j < count; j++)
        begin
            case (kind)
                FILL_FULL:
                    v = SAMPLE_W'($urandom);
                FILL_ALIGNED:
                begin
                    // match the sign of one mode row so that mode saturates
                    v = S_MAX - SAMPLE_W'($urandom_range(0, 1 << 20));
                    if ((coef_tab[row][j] < 0) ^ neg)
                        v = ~v;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = '0;
                        1:       v = SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
                        2:       v = SAMPLE_W'($urandom);
                        default: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    endcase
                end
            endcase
            stim_q.push_back('{value: v, wait_drain: wait_first && (j == 0)});
        end
    endtask

    function automatic idle_phase_e idle_phase();
        return idle_phase_e'((samples_taken / POINTS) % 4);
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            PH_SEND: return $urandom_range(0, 99) < 69;
            PH_BOTH: return $urandom_range(0, 99) < 15;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase())
            PH_RECV: return $urandom_range(0, 99) < 69;
            PH_BOTH: return $urandom_range(0, 99) < 15;
            default: return 1'b0;
        endcase
    endfunction

    // Sample driver: hold a request until taken, then offer the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_in    <= '0;
            drain_armed  <= 1'b0;
        end
        else if (!sample_valid || sample_ready)
        begin
            if (stim_q.size() == 0 || sender_idles())
            begin
                sample_valid <= 1'b0;
            end
            else if (stim_q[0].wait_drain && (!drain_armed || mode_q.size() != 0))
            begin
                // hold off until every queued mode result has come back
                drain_armed  <= 1'b1;
                sample_valid <= 1'b0;
            end
            else
            begin
                sample_in    <= stim_q[0].value;
                sample_valid <= 1'b1;
                drain_armed  <= 1'b0;
                void'(stim_q.pop_front());
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_ready <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            mode_ready <= 1'b0;
        end
        else if (!hold_done && results_got >= HOLD_AT)
        begin
            hold_left  <= HOLD_LEN;
            hold_done  <= 1'b1;
            mode_ready <= 1'b0;
        end
        else
        begin
            mode_ready <= !receiver_stalls();
        end
    end

    // Monitor: predict on accepted samples, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (mode_valid && mode_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (sample_valid && sample_ready)
            begin
                take_sample(sample_in);
                samples_taken++;
            end
            if (mode_valid && mode_ready)
            begin
                results_got++;
                if (mode_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected mode %0d value %0d",
                                              mode_index, mode_value));
                end
                else
                begin
                    mode_head = mode_q.pop_front();
                    if (mode_value !== mode_head.value || mode_index !== mode_head.index ||
                        last_mode !== mode_head.last || saturated !== mode_head.sat)
                        report_mismatch($sformatf(
                            "mode %0d: got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
                            mode_head.index, mode_value, mode_index, last_mode, saturated,
                            mode_head.value, mode_head.index, mode_head.last, mode_head.sat));
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        build_coefs();
        // zero, one, minus one, then full scale high and low halves
        for (int j = 0; j < POINTS; j++)
        begin
            case (j)
                0:       stim_q.push_back('{value: '0, wait_drain: 1'b0});
                1:       stim_q.push_back('{value: SAMPLE_W'(1), wait_drain: 1'b0});
                2:       stim_q.push_back('{value: '1, wait_drain: 1'b0});
                default: stim_q.push_back('{value: (j < POINTS / 2) ? S_MAX : S_MIN,
                                            wait_drain: 1'b0});
            endcase
        end
        add_block(FILL_ALIGNED, POINTS, 1'b1, 1'b0);
        add_block(FILL_MIXED, POINTS, 1'b0, 1'b1);
        // trailing partial block: must produce nothing
        add_block(FILL_FULL, $urandom_range(1, POINTS / 2), 1'b0, 1'b0);
        total_items = stim_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_taken != total_items)
            @(posedge clk);
        while (mode_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
